// ----- design/ecft_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ecft_pkg
// Shared types, byte codes and the CRC-32 byte step of the escaped CRC
// frame transmitter.
// ============================================================================
package ecft_pkg;

    localparam logic [7:0]  ESC_BYTE   = 8'h99;
    localparam logic [7:0]  PAD_BYTE   = 8'h9A;
    localparam logic [7:0]  SOF_BYTE   = 8'h9B;
    localparam logic [7:0]  EOF_FINAL  = 8'h9C;
    localparam logic [7:0]  EOF_MORE   = 8'h9D;
    localparam logic [7:0]  ESC_XOR    = 8'h10;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;

    localparam int ECFT_FRAME_LEN = 48;
    localparam int QUEUE_DEPTH    = 4;

    // One symbol handed from the front end to the framer.
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       close;
    } ecft_token_t;

    function automatic logic needs_escape(input logic [7:0] b);
        needs_escape = (b >= ESC_BYTE) && (b <= EOF_MORE);
    endfunction

    // Reflected CRC-32 over one byte, one bit per step.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc32_byte = c;
    endfunction

endpackage

// ----- design/ecft_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ecft_front
// Accepts message bytes, keeps the CRC and turns each byte into escaped
// symbols, one per cycle while tok_ready is high; a final byte is followed by the CRC and a close.
// ============================================================================
module ecft_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 tok_valid,
    input  logic                 tok_ready,
    output ecft_pkg::ecft_token_t tok
);
    import ecft_pkg::*;

    localparam logic [2:0] STEP_MSG   = 3'd0;
    localparam logic [2:0] STEP_CRC0  = 3'd1;
    localparam logic [2:0] STEP_CRC1  = 3'd2;
    localparam logic [2:0] STEP_CRC2  = 3'd3;
    localparam logic [2:0] STEP_CRC3  = 3'd4;
    localparam logic [2:0] STEP_CLOSE = 3'd5;

    logic        busy_reg, busy_next;
    logic        esc_reg, esc_next;
    logic [2:0]  step_reg, step_next;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic [31:0] crc_reg;
    logic [31:0] fin_reg;
    logic [31:0] crc_new;
    logic [7:0]  cur_byte;
    logic        cur_esc;
    logic        push;
    logic        item_end;
    logic        accept;

    always_comb
    begin
        case (step_reg)
            STEP_MSG:  cur_byte = data_reg;
            STEP_CRC0: cur_byte = fin_reg[7:0];
            STEP_CRC1: cur_byte = fin_reg[15:8];
            STEP_CRC2: cur_byte = fin_reg[23:16];
            STEP_CRC3: cur_byte = fin_reg[31:24];
            default:   cur_byte = data_reg;
        endcase
    end

    assign cur_esc  = needs_escape(cur_byte);
    assign item_end = (step_reg == STEP_CLOSE) ||
                      ((step_reg == STEP_MSG) && !last_reg && (esc_reg || !cur_esc));

    always_comb
    begin
        tok.run_end = item_end;
        tok.close   = (step_reg == STEP_CLOSE);
        if (step_reg == STEP_CLOSE)
        begin
            tok.data = EOF_FINAL;
        end
        else if (esc_reg)
        begin
            tok.data = cur_byte ^ ESC_XOR;
        end
        else if (cur_esc)
        begin
            tok.data = ESC_BYTE;
        end
        else
        begin
            tok.data = cur_byte;
        end
    end

    assign tok_valid = busy_reg;
    assign push      = busy_reg && tok_ready;
    assign in_stall  = busy_reg && !(push && item_end);
    assign accept    = in_valid && !in_stall;
    assign crc_new   = crc32_byte(crc_reg, data_byte);

    always_comb
    begin
        busy_next = busy_reg;
        esc_next  = esc_reg;
        step_next = step_reg;
        if (push)
        begin
            if (item_end)
            begin
                busy_next = 1'b0;
            end
            if (step_reg != STEP_CLOSE && !esc_reg && cur_esc)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                esc_next = 1'b0;
                if (step_reg != STEP_CLOSE)
                begin
                    step_next = step_reg + 3'd1;
                end
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
            esc_next  = 1'b0;
            step_next = STEP_MSG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            esc_reg  <= 1'b0;
            step_reg <= STEP_MSG;
            crc_reg  <= CRC_INIT;
        end
        else
        begin
            busy_reg <= busy_next;
            esc_reg  <= esc_next;
            step_reg <= step_next;
            if (accept)
            begin
                crc_reg <= last_byte ? CRC_INIT : crc_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
            fin_reg  <= ~crc_new;
        end
    end

endmodule

// ----- design/ecft_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ecft_queue
// Short first-in first-out queue of symbols between front end and framer.
// ============================================================================
module ecft_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  ecft_pkg::ecft_token_t wr_tok,
    output logic                  rd_valid,
    input  logic                  rd_pop,
    output ecft_pkg::ecft_token_t rd_tok
);
    import ecft_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    ecft_token_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != (PTR_W + 1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_tok   = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_tok;
        end
    end

endmodule

// ----- design/ecft_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ecft_back
// Framer: wraps symbols into frames with start, pad and end markers and
// drives the registered output word.
// ============================================================================
module ecft_back #(
    parameter int FRAME_LEN = ecft_pkg::ECFT_FRAME_LEN
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tok_valid,
    output logic                  tok_pop,
    input  ecft_pkg::ecft_token_t tok,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            out_byte,
    output logic                  run_last,
    output logic                  message_end
);
    import ecft_pkg::*;

    localparam int             FILL_W   = $clog2(FRAME_LEN);
    localparam logic [FILL_W-1:0] DATA_MAX = FILL_W'(FRAME_LEN - 2);

    logic              open_reg, open_next;
    logic              pend_reg, pend_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg, byte_next;
    logic              run_last_reg, run_last_next;
    logic              message_end_reg, message_end_next;
    logic              load;

    assign load = tok_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        open_next        = open_reg;
        pend_next        = pend_reg;
        fill_next        = fill_reg;
        tok_pop          = 1'b0;
        byte_next        = tok.data;
        run_last_next    = 1'b0;
        message_end_next = 1'b0;
        if (tok.close)
        begin
            if (fill_reg < DATA_MAX)
            begin
                byte_next = PAD_BYTE;
                fill_next = fill_reg + 1'b1;
            end
            else
            begin
                byte_next        = EOF_FINAL;
                run_last_next    = 1'b1;
                message_end_next = 1'b1;
                tok_pop          = load;
                open_next        = 1'b0;
                pend_next        = 1'b0;
                fill_next        = '0;
            end
        end
        else if (pend_reg)
        begin
            byte_next = EOF_MORE;
            pend_next = 1'b0;
            open_next = 1'b0;
            fill_next = '0;
        end
        else if (!open_reg)
        begin
            byte_next = SOF_BYTE;
            open_next = 1'b1;
            fill_next = '0;
        end
        else
        begin
            run_last_next = tok.run_end;
            tok_pop       = load;
            fill_next     = fill_reg + 1'b1;
            pend_next     = (fill_next >= DATA_MAX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                open_reg <= open_next;
                pend_reg <= pend_next;
                fill_reg <= fill_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg    <= byte_next;
            run_last_reg    <= run_last_next;
            message_end_reg <= message_end_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign message_end = message_end_reg;

    // A held end marker only exists on a full, open frame.
    a_pend_full: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (open_reg && fill_reg == DATA_MAX))
        else $error("end marker pending on a frame that is not full");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DATA_MAX)
        else $error("frame fill beyond data length");

    a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && message_end_reg) |-> (out_byte_reg == EOF_FINAL && run_last_reg))
        else $error("message end flag on a byte other than the final marker");

    a_close_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (load && tok_pop && tok.close) |=> (!open_reg && !pend_reg && fill_reg == '0))
        else $error("frame state not cleared after message close");

endmodule

// ----- design/escaped_crc_frame_transmitter.sv -----
`timescale 1ns / 1ps
// ============================================================================
// escaped_crc_frame_transmitter
// Byte-stuffing framer with CRC-32: escapes message bytes, appends the CRC
// and cuts the stream into marked frames of FRAME_LEN bytes.
// ============================================================================
//
//  Channel  Handshake             Word fields
//  -------  --------------------  ------------------------------------
//  input    in_valid / in_stall   data_byte[7:0], last_byte
//  output   out_valid / out_stall out_byte[7:0], run_last, message_end
//
// The output side delivers one byte per cycle from its output register while
// out_stall is low. An input word causes one output byte for a plain byte in
// an open frame, two for an escaped byte, two more at a frame boundary, and
// for the final word the CRC, the padding and the closing marker (up to 58
// bytes). The output port sets the rate.
// The front end emits one symbol per cycle into a four-entry queue while the
// queue has room, and takes the next input word in the cycle it emits the last
// symbol of the current one. Reset clears the CRC, frame state, queue and output valid at once.
// A stalled output holds its word while the front end keeps filling the queue.
//
module escaped_crc_frame_transmitter #(
    parameter int FRAME_LEN = ecft_pkg::ECFT_FRAME_LEN
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       message_end
);
    import ecft_pkg::*;

    // Symbols from the front end into the queue.
    ecft_token_t front_tok;
    logic        front_valid;
    logic        front_ready;

    // Symbols from the queue head into the framer.
    ecft_token_t head_tok;
    logic        head_valid;
    logic        head_pop;

    // The front end classifies each byte (escape or not), runs the CRC and,
    // after a final byte, produces the four CRC bytes and a close symbol.
    ecft_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .tok_valid (front_valid),
        .tok_ready (front_ready),
        .tok       (front_tok)
    );

    // The queue decouples symbol production from frame assembly, so
    // each side stalls on its own.
    ecft_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_tok   (front_tok),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_tok   (head_tok)
    );

    // The framer inserts start markers, defers the end marker of a full
    // frame until it knows whether more data follows, and pads the last frame.
    ecft_back #(
        .FRAME_LEN (FRAME_LEN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_valid   (head_valid),
        .tok_pop     (head_pop),
        .tok         (head_tok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .message_end (message_end)
    );

endmodule
